// ===== sv/pshq_pkg.sv =====
// Package with the shared types, codes and defaults of the handle ring queue.
`timescale 1ns / 1ps
package pshq_pkg;

  localparam int DEF_SOCKET_COUNT = 8;
  localparam int DEF_RING_DEPTH   = 16;
  localparam int DEF_HANDLE_BITS  = 32;

  localparam int HANDLE_PORT_W = 32;
  localparam int SOCKET_W      = 8;

  localparam logic [SOCKET_W-1:0] ALL_SOCKETS = 8'hFF;

  localparam logic [1:0] CMD_STORE  = 2'd0;
  localparam logic [1:0] CMD_GET    = 2'd1;
  localparam logic [1:0] CMD_REINIT = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_EMPTY   = 2'd2;
  localparam logic [1:0] ST_BADSOCK = 2'd3;

  localparam logic [1:0] KIND_OTHER = 2'd0;
  localparam logic [1:0] KIND_UDP   = 2'd1;
  localparam logic [1:0] KIND_TCP   = 2'd2;

  localparam logic [1:0] REL_NONE   = 2'd0;
  localparam logic [1:0] REL_NETBUF = 2'd1;
  localparam logic [1:0] REL_PBUF   = 2'd2;

  // Operation codes produced by the classifier.
  localparam logic [2:0] OP_NOP        = 3'd0;
  localparam logic [2:0] OP_BAD        = 3'd1;
  localparam logic [2:0] OP_STORE      = 3'd2;
  localparam logic [2:0] OP_GET        = 3'd3;
  localparam logic [2:0] OP_REINIT     = 3'd4;
  localparam logic [2:0] OP_REINIT_ALL = 3'd5;

  typedef struct packed {
    logic [2:0]               code;
    logic [SOCKET_W-1:0]      sock;
    logic [HANDLE_PORT_W-1:0] handle;
    logic [1:0]               kind;
  } op_t;

endpackage

// ===== sv/pshq_if.sv =====
// Handshake interfaces for the request and result channels.
`timescale 1ns / 1ps
interface pshq_req_if import pshq_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [1:0]               command;
  logic [SOCKET_W-1:0]      socket;
  logic [HANDLE_PORT_W-1:0] handle_in;
  logic [1:0]               socket_kind;

  modport source (output valid, command, socket, handle_in, socket_kind, input ready);
  modport sink (input valid, command, socket, handle_in, socket_kind, output ready);
endinterface

interface pshq_rsp_if import pshq_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [1:0]               status;
  logic [HANDLE_PORT_W-1:0] handle_out;
  logic [1:0]               release_kind;
  logic                     last_result;

  modport source (output valid, status, handle_out, release_kind, last_result, input ready);
  modport sink (input valid, status, handle_out, release_kind, last_result, output ready);
endinterface

// ===== sv/pshq_front.sv =====
// Front end: accepts request words and classifies them into operations.
`timescale 1ns / 1ps
module pshq_front import pshq_pkg::*; #(
  parameter int SOCKET_COUNT = DEF_SOCKET_COUNT,
  parameter int HANDLE_BITS  = DEF_HANDLE_BITS
) (
  pshq_req_if.sink req,
  output op_t      op,
  output logic     op_valid,
  input  logic     op_ready
);

  localparam logic [HANDLE_PORT_W-1:0] HMASK = (HANDLE_BITS >= HANDLE_PORT_W) ?
      {HANDLE_PORT_W{1'b1}} : HANDLE_PORT_W'((64'd1 << HANDLE_BITS) - 64'd1);

  logic [HANDLE_PORT_W-1:0] handle_masked;

  assign handle_masked = req.handle_in & HMASK;
  assign op_valid      = req.valid;
  assign req.ready     = op_ready;

  always_comb begin
    op.sock   = req.socket;
    op.handle = handle_masked;
    op.kind   = req.socket_kind;
    op.code   = OP_NOP;
    if (req.command != CMD_STORE && req.command != CMD_GET && req.command != CMD_REINIT) begin
      op.code = OP_NOP;
    end else if (req.command == CMD_REINIT && req.socket == ALL_SOCKETS) begin
      op.code = OP_REINIT_ALL;
    end else if (req.socket >= SOCKET_W'(SOCKET_COUNT)) begin
      op.code = OP_BAD;
    end else begin
      case (req.command)
        CMD_STORE: begin
          // A zero handle is taken and dropped without touching the ring.
          op.code = (handle_masked == '0) ? OP_NOP : OP_STORE;
        end
        CMD_GET:    op.code = OP_GET;
        CMD_REINIT: op.code = OP_REINIT;
        default:    op.code = OP_NOP;
      endcase
    end
  end

endmodule

// ===== sv/pshq_op_queue.sv =====
// Two-entry queue of classified operations between the front and back ends.
`timescale 1ns / 1ps
module pshq_op_queue import pshq_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  op_t  push_op,
  input  logic push_valid,
  output logic push_ready,
  output op_t  pop_op,
  output logic pop_valid,
  input  logic pop
);

  op_t        slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_op     = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== sv/pshq_back.sv =====
// Back end: ring state, handle memory, drain sequencer and result register.
`timescale 1ns / 1ps
module pshq_back import pshq_pkg::*; #(
  parameter int SOCKET_COUNT = DEF_SOCKET_COUNT,
  parameter int RING_DEPTH   = DEF_RING_DEPTH,
  parameter int HANDLE_BITS  = DEF_HANDLE_BITS
) (
  input  logic       clk,
  input  logic       rst,
  input  op_t        op,
  input  logic       op_valid,
  output logic       op_pop,
  pshq_rsp_if.source rsp
);

  localparam int SKW       = (SOCKET_COUNT > 1) ? $clog2(SOCKET_COUNT) : 1;
  localparam int PTR_W     = $clog2(RING_DEPTH);
  localparam int HW        = (HANDLE_BITS < HANDLE_PORT_W) ? HANDLE_BITS : HANDLE_PORT_W;
  localparam int AW        = SKW + PTR_W;
  localparam int MEM_DEPTH = 1 << AW;
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(RING_DEPTH - 1);

  localparam logic S_IDLE  = 1'b0;
  localparam logic S_DRAIN = 1'b1;

  // Occupancy bits stand in for the nonzero test of each slot.
  logic [SOCKET_COUNT-1:0][RING_DEPTH-1:0] occ;
  logic [PTR_W-1:0] front_ptr [SOCKET_COUNT];
  logic [PTR_W-1:0] rear_ptr  [SOCKET_COUNT];
  logic [1:0]       kind_tab  [SOCKET_COUNT];

  logic [HW-1:0] mem [MEM_DEPTH];
  logic [HW-1:0] rd_data;

  logic             state;
  logic [SKW-1:0]   cur_sock;
  logic [PTR_W-1:0] cur_ptr;
  logic [PTR_W-1:0] cnt;
  logic [1:0]       cur_rel;
  logic [1:0]       new_kind;
  logic             is_get;

  logic                     out_valid;
  logic [1:0]               out_status;
  logic [HANDLE_PORT_W-1:0] out_handle;
  logic [1:0]               out_rel;
  logic                     out_last;

  logic             out_free;
  logic [SKW-1:0]   op_sock;
  logic [PTR_W-1:0] f_ptr;
  logic [PTR_W-1:0] r_ptr;
  logic             front_occ;
  logic             rear_occ;
  logic             drains;
  logic             needs_read;
  logic             take;
  logic [PTR_W-1:0] nxt_ptr;
  logic             drain_last;
  logic             emit;
  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  logic             mem_re;
  logic [AW-1:0]    mem_raddr;

  function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
    wrap_inc = (p == LAST_PTR) ? '0 : p + PTR_W'(1);
  endfunction

  assign rsp.valid        = out_valid;
  assign rsp.status       = out_status;
  assign rsp.handle_out   = out_handle;
  assign rsp.release_kind = out_rel;
  assign rsp.last_result  = out_last;

  assign out_free  = !out_valid || rsp.ready;
  assign op_sock   = op.sock[SKW-1:0];
  assign f_ptr     = front_ptr[op_sock];
  assign r_ptr     = rear_ptr[op_sock];
  assign front_occ = occ[op_sock][f_ptr];
  assign rear_occ  = occ[op_sock][r_ptr];
  assign drains    = (kind_tab[op_sock] == KIND_UDP) || (kind_tab[op_sock] == KIND_TCP);

  assign needs_read = ((op.code == OP_GET) && front_occ) ||
                      ((op.code == OP_REINIT) && drains && front_occ);
  assign take       = (state == S_IDLE) && op_valid && (needs_read || out_free);
  assign op_pop     = take;

  assign nxt_ptr    = wrap_inc(cur_ptr);
  assign drain_last = is_get || (cnt == LAST_PTR) || !occ[cur_sock][nxt_ptr];
  assign emit       = (state == S_DRAIN) && out_free;

  assign mem_we    = take && !needs_read && (op.code == OP_STORE) && !rear_occ;
  assign mem_waddr = {op_sock, r_ptr};
  assign mem_re    = (take && needs_read) || (emit && !drain_last);
  assign mem_raddr = (state == S_IDLE) ? {op_sock, f_ptr} : {cur_sock, nxt_ptr};

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= op.handle[HW-1:0];
    end
    if (mem_re) begin
      rd_data <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      occ       <= '0;
      for (int i = 0; i < SOCKET_COUNT; i++) begin
        front_ptr[i] <= '0;
        rear_ptr[i]  <= '0;
        kind_tab[i]  <= KIND_OTHER;
      end
    end else begin
      if (out_valid && rsp.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (take && needs_read) begin
            state    <= S_DRAIN;
            cur_sock <= op_sock;
            cur_ptr  <= f_ptr;
            cnt      <= '0;
            is_get   <= (op.code == OP_GET);
            new_kind <= op.kind;
            if (op.code == OP_GET) begin
              cur_rel <= REL_NONE;
            end else begin
              cur_rel <= (kind_tab[op_sock] == KIND_TCP) ? REL_PBUF : REL_NETBUF;
            end
          end else if (take) begin
            out_valid  <= 1'b1;
            out_last   <= 1'b1;
            out_handle <= '0;
            out_rel    <= REL_NONE;
            out_status <= ST_OK;
            case (op.code)
              OP_BAD: out_status <= ST_BADSOCK;
              OP_STORE: begin
                if (rear_occ) begin
                  out_status <= ST_FULL;
                end else begin
                  occ[op_sock][r_ptr] <= 1'b1;
                  rear_ptr[op_sock]   <= wrap_inc(r_ptr);
                end
              end
              OP_GET: out_status <= ST_EMPTY;
              OP_REINIT: begin
                occ[op_sock]       <= '0;
                front_ptr[op_sock] <= '0;
                rear_ptr[op_sock]  <= '0;
                kind_tab[op_sock]  <= op.kind;
              end
              OP_REINIT_ALL: begin
                occ <= '0;
                for (int i = 0; i < SOCKET_COUNT; i++) begin
                  front_ptr[i] <= '0;
                  rear_ptr[i]  <= '0;
                  kind_tab[i]  <= op.kind;
                end
              end
              default: out_status <= ST_OK;
            endcase
          end
        end
        S_DRAIN: begin
          if (emit) begin
            out_valid  <= 1'b1;
            out_status <= ST_OK;
            out_handle <= HANDLE_PORT_W'(rd_data);
            out_rel    <= cur_rel;
            out_last   <= drain_last;
            if (is_get) begin
              occ[cur_sock][cur_ptr] <= 1'b0;
              front_ptr[cur_sock]    <= nxt_ptr;
              state <= S_IDLE;
            end else if (drain_last) begin
              occ[cur_sock]       <= '0;
              front_ptr[cur_sock] <= '0;
              rear_ptr[cur_sock]  <= '0;
              kind_tab[cur_sock]  <= new_kind;
              state <= S_IDLE;
            end else begin
              occ[cur_sock][cur_ptr] <= 1'b0;
              cur_ptr <= nxt_ptr;
              cnt     <= cnt + PTR_W'(1);
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== sv/per_socket_handle_ring_queue.sv =====
// Top level of the per-socket handle ring queue.
//
//   channel  dir  payload                                          accepted when
//   req      in   command, socket, handle_in, socket_kind          valid && ready
//   rsp      out  status, handle_out, release_kind, last_result    valid && ready
//
// Stores, bad-socket, empty-get and no-op words and reinitialises with nothing to
// drain are answered from the idle state; the rest go through the drain state, as
// each handle comes from a registered memory read. A drain emits one word
// per cycle once the first read is back and the output is free, up to one ring.
// The two-entry operation queue lets requests arrive while the back end works.
// Reset clears all rings, pointers and kinds at once through occupancy bits.
// A stalled result register holds the back end; the queue then fills and
// deasserts req.ready.
`timescale 1ns / 1ps
module per_socket_handle_ring_queue import pshq_pkg::*; #(
  parameter int SOCKET_COUNT = DEF_SOCKET_COUNT,
  parameter int RING_DEPTH   = DEF_RING_DEPTH,
  parameter int HANDLE_BITS  = DEF_HANDLE_BITS
) (
  input logic      clk,
  input logic      rst,
  pshq_req_if.sink req,
  pshq_rsp_if.source rsp
);

  op_t  front_op;
  logic front_valid;
  logic front_ready;
  op_t  back_op;
  logic back_valid;
  logic back_pop;

  pshq_front #(
    .SOCKET_COUNT (SOCKET_COUNT),
    .HANDLE_BITS  (HANDLE_BITS)
  ) u_front (
    .req      (req),
    .op       (front_op),
    .op_valid (front_valid),
    .op_ready (front_ready)
  );

  pshq_op_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_op    (front_op),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .pop_op     (back_op),
    .pop_valid  (back_valid),
    .pop        (back_pop)
  );

  pshq_back #(
    .SOCKET_COUNT (SOCKET_COUNT),
    .RING_DEPTH   (RING_DEPTH),
    .HANDLE_BITS  (HANDLE_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .op       (back_op),
    .op_valid (back_valid),
    .op_pop   (back_pop),
    .rsp      (rsp)
  );

endmodule
